// ===== src/bss_pkg.sv =====
package bss_pkg;

  localparam int BIN_COUNT   = 1024;
  localparam int ADDR_W      = $clog2(BIN_COUNT);
  localparam int BIN_W       = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;
  localparam int CNT_W       = 32;
  localparam int SUM_W       = 48;
  localparam int SQ_W        = 64;
  localparam int PROD_W      = 2 * SAMPLE_BITS;
  localparam int HALF_W      = SUM_W / 2;
  localparam int MUL_W       = 32;
  localparam int MULP_W      = 2 * MUL_W;
  localparam int ACC_W       = 96;
  localparam int MEAN_W      = 24;
  localparam int STD_W       = 24;
  localparam int DIV_W       = 128;
  localparam int DVS_W       = 64;
  localparam int ROOT_W      = 2 * STD_W + 2;
  localparam int DIV_STEPS   = DIV_W;
  localparam int SQRT_STEPS  = STD_W + 1;
  localparam int STEP_W      = 7;

  localparam logic OP_ACCUM  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]              total;
    logic [CNT_W-1:0]              valid;
    logic signed [SUM_W-1:0]       sum;
    logic [SQ_W-1:0]               sq;
    logic signed [SAMPLE_BITS-1:0] minv;
    logic signed [SAMPLE_BITS-1:0] maxv;
    logic                          ovf;
  } entry_t;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = SAMPLE_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);

  localparam entry_t RESET_ENTRY = '{
    total: '0, valid: '0, sum: '0, sq: '0,
    minv: SAMPLE_MAX, maxv: ~SAMPLE_MAX, ovf: 1'b0
  };

  typedef enum logic [2:0] {
    MS_A_LO, MS_A_HI, MS_B_LL, MS_B_LH, MS_B_HH, MS_M
  } mul_step_t;

  typedef enum logic [13:0] {
    S_CLEAR    = 14'b00000000000001,
    S_IDLE     = 14'b00000000000010,
    S_UPD      = 14'b00000000000100,
    S_MUL      = 14'b00000000001000,
    S_MUL_WAIT = 14'b00000000010000,
    S_MEAN_LD  = 14'b00000000100000,
    S_MEAN_DIV = 14'b00000001000000,
    S_MEAN_FIN = 14'b00000010000000,
    S_STD_LD   = 14'b00000100000000,
    S_STD_DIV  = 14'b00001000000000,
    S_SQ_LD    = 14'b00010000000000,
    S_SQ       = 14'b00100000000000,
    S_STD_FIN  = 14'b01000000000000,
    S_OUT      = 14'b10000000000000
  } state_t;

  typedef struct packed {
    logic      clr_en;
    logic      acc_wr;
    logic      mul_en;
    mul_step_t mul_step;
    logic      mean_ld;
    logic      std_ld;
    logic      div_step;
    logic      mean_fin;
    logic      sq_ld;
    logic      sq_step;
    logic      std_fin;
    logic      std_clr;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic n_ge1;
    logic n_ge2;
    logic var_pos;
  } status_t;

endpackage

// ===== src/bss_ctrl.sv =====
module bss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic             operation,
  input  bss_pkg::status_t status,
  output bss_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             result_valid
);
  import bss_pkg::*;

  state_t            state, state_next;
  mul_step_t         step, step_next;
  logic [STEP_W-1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step  <= MS_A_LO;
      cnt   <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.mul_step = step;
    case (state)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          state_next = (operation == OP_REPORT) ? S_MUL : S_UPD;
          step_next  = MS_A_LO;
        end
      end
      S_UPD: begin
        cmd.acc_wr = 1'b1;
        state_next = S_IDLE;
      end
      S_MUL: begin
        cmd.mul_en  = 1'b1;
        cmd.std_clr = 1'b1;
        case (step)
          MS_A_LO: step_next = MS_A_HI;
          MS_A_HI: step_next = MS_B_LL;
          MS_B_LL: step_next = MS_B_LH;
          MS_B_LH: step_next = MS_B_HH;
          MS_B_HH: step_next = MS_M;
          default: state_next = S_MUL_WAIT;
        endcase
      end
      S_MUL_WAIT: state_next = status.n_ge1 ? S_MEAN_LD : S_OUT;
      S_MEAN_LD: begin
        cmd.mean_ld = 1'b1;
        cnt_next    = STEP_W'(DIV_STEPS - 1);
        state_next  = S_MEAN_DIV;
      end
      S_MEAN_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) state_next = S_MEAN_FIN;
        else cnt_next = cnt - 1'b1;
      end
      S_MEAN_FIN: begin
        cmd.mean_fin = 1'b1;
        state_next   = (status.n_ge2 && status.var_pos) ? S_STD_LD : S_OUT;
      end
      S_STD_LD: begin
        cmd.std_ld = 1'b1;
        cnt_next   = STEP_W'(DIV_STEPS - 1);
        state_next = S_STD_DIV;
      end
      S_STD_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) state_next = S_SQ_LD;
        else cnt_next = cnt - 1'b1;
      end
      S_SQ_LD: begin
        cmd.sq_ld  = 1'b1;
        cnt_next   = STEP_W'(SQRT_STEPS - 1);
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq_step = 1'b1;
        if (cnt == '0) state_next = S_STD_FIN;
        else cnt_next = cnt - 1'b1;
      end
      S_STD_FIN: begin
        cmd.std_fin = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_OUT);

  a_accum_update: assert property (@(posedge clk) disable iff (rst)
    accept && operation == OP_ACCUM |=> state == S_UPD)
    else $error("accumulate item not followed by update");
  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");
  a_units_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.div_step && cmd.sq_step))
    else $error("divider and root stepping together");
  a_mean_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_MEAN_LD |-> status.n_ge1)
    else $error("mean divide started on empty bin");

endmodule

// ===== src/bss_datapath.sv =====
module bss_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  bss_pkg::cmd_t                       cmd,
  output bss_pkg::status_t                    status,
  input  logic                                accept,
  input  logic [bss_pkg::BIN_W-1:0]           bin,
  input  logic signed [bss_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                sample_is_nan,
  output logic [bss_pkg::BIN_W-1:0]           bin_out,
  output logic [bss_pkg::CNT_W-1:0]           total_count,
  output logic [bss_pkg::CNT_W-1:0]           nan_count,
  output logic signed [bss_pkg::SAMPLE_BITS-1:0] min_value,
  output logic signed [bss_pkg::SAMPLE_BITS-1:0] max_value,
  output logic signed [bss_pkg::SUM_W-1:0]    sum_value,
  output logic signed [bss_pkg::MEAN_W-1:0]   mean_value,
  output logic [bss_pkg::STD_W-1:0]           stdev_value,
  output logic                                has_values,
  output logic                                has_stdev,
  output logic                                overflow
);
  import bss_pkg::*;

  localparam logic [DIV_W-1:0]  MEAN_NEG_MAX = DIV_W'(1) << (MEAN_W - 1);
  localparam logic [DIV_W-1:0]  MEAN_POS_MAX = MEAN_NEG_MAX - DIV_W'(1);
  localparam logic [DIV_W-1:0]  ROOT_CAP     = DIV_W'(1) << (2 * STD_W);
  localparam logic [ROOT_W-1:0] ROOT_TOP     = ROOT_W'(1) << (2 * STD_W);
  localparam logic [ROOT_W-1:0] STD_SAT      = ROOT_W'({STD_W{1'b1}});

  entry_t mem [BIN_COUNT];
  entry_t ent, upd;

  logic [ADDR_W-1:0]             clr_addr;
  logic [ADDR_W-1:0]             req_addr;
  logic [BIN_W-1:0]              req_bin;
  logic                          req_ok;
  logic signed [SAMPLE_BITS-1:0] req_sample;
  logic                          req_nan;
  logic                          bin_ok_in;

  assign bin_ok_in = {{(32 - BIN_W){1'b0}}, bin} < 32'(BIN_COUNT);

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (cmd.clr_en) clr_addr <= clr_addr + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent        <= bin_ok_in ? mem[bin[ADDR_W-1:0]] : RESET_ENTRY;
      req_addr   <= bin[ADDR_W-1:0];
      req_bin    <= bin;
      req_ok     <= bin_ok_in;
      req_sample <= sample;
      req_nan    <= sample_is_nan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) mem[clr_addr] <= RESET_ENTRY;
    else if (cmd.acc_wr && req_ok) mem[req_addr] <= upd;
  end

  // sample update of one entry
  logic signed [SUM_W:0]  s_wide;
  logic signed [PROD_W-1:0] v_sq;
  logic [SQ_W:0]          sq_wide;

  always_comb begin
    upd     = ent;
    s_wide  = (SUM_W + 1)'(ent.sum) + (SUM_W + 1)'(req_sample);
    v_sq    = req_sample * req_sample;
    sq_wide = {1'b0, ent.sq} + (SQ_W + 1)'(unsigned'(v_sq));
    if (&ent.total) upd.ovf = 1'b1;
    else upd.total = ent.total + 1'b1;
    if (!req_nan) begin
      if (&ent.valid) upd.ovf = 1'b1;
      else upd.valid = ent.valid + 1'b1;
      if (s_wide[SUM_W] != s_wide[SUM_W-1]) begin
        upd.ovf = 1'b1;
        upd.sum = s_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
        upd.sum = s_wide[SUM_W-1:0];
      end
      if (sq_wide[SQ_W]) begin
        upd.ovf = 1'b1;
        upd.sq  = '1;
      end else begin
        upd.sq = sq_wide[SQ_W-1:0];
      end
      if (req_sample < ent.minv) upd.minv = req_sample;
      if (req_sample > ent.maxv) upd.maxv = req_sample;
    end
  end

  // moment products through one 32x32 multiplier
  logic [SUM_W-1:0]  mag;
  logic [MUL_W-1:0]  op_a, op_b;
  logic [MULP_W-1:0] prod;
  mul_step_t         prod_tag;
  logic              prod_vld;
  logic [ACC_W-1:0]  a_acc, b_acc;
  logic [DVS_W-1:0]  dvs_m;

  assign mag = ent.sum[SUM_W-1] ? SUM_W'(-ent.sum) : SUM_W'(ent.sum);

  always_comb begin
    op_a = ent.valid;
    op_b = ent.sq[MUL_W-1:0];
    case (cmd.mul_step)
      MS_A_LO: op_b = ent.sq[MUL_W-1:0];
      MS_A_HI: op_b = ent.sq[SQ_W-1:MUL_W];
      MS_B_LL: begin
        op_a = MUL_W'(mag[HALF_W-1:0]);
        op_b = MUL_W'(mag[HALF_W-1:0]);
      end
      MS_B_LH: begin
        op_a = MUL_W'(mag[HALF_W-1:0]);
        op_b = MUL_W'(mag[SUM_W-1:HALF_W]);
      end
      MS_B_HH: begin
        op_a = MUL_W'(mag[SUM_W-1:HALF_W]);
        op_b = MUL_W'(mag[SUM_W-1:HALF_W]);
      end
      MS_M: op_b = ent.valid - 1'b1;
      default: op_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) prod_vld <= 1'b0;
    else prod_vld <= cmd.mul_en;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod     <= op_a * op_b;
      prod_tag <= cmd.mul_step;
    end
    if (prod_vld) begin
      case (prod_tag)
        MS_A_LO: a_acc <= ACC_W'(prod);
        MS_A_HI: a_acc <= a_acc + (ACC_W'(prod) << MUL_W);
        MS_B_LL: b_acc <= ACC_W'(prod);
        MS_B_LH: b_acc <= b_acc + (ACC_W'(prod) << (HALF_W + 1));
        MS_B_HH: b_acc <= b_acc + (ACC_W'(prod) << SUM_W);
        MS_M:    dvs_m <= prod;
        default: dvs_m <= prod;
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0] dq;
  logic [DVS_W:0]   rem;
  logic [DVS_W-1:0] dv;
  logic [DVS_W:0]   rem_sh;
  logic             q_bit;

  assign rem_sh = {rem[DVS_W-1:0], dq[DIV_W-1]};
  assign q_bit  = rem_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (cmd.mean_ld) begin
      dq  <= (DIV_W'(mag) << FRAC_BITS) + DIV_W'(ent.valid >> 1);
      rem <= '0;
      dv  <= DVS_W'(ent.valid);
    end else if (cmd.std_ld) begin
      dq  <= DIV_W'(a_acc - b_acc) << (2 * FRAC_BITS);
      rem <= '0;
      dv  <= dvs_m;
    end else if (cmd.div_step) begin
      rem <= q_bit ? rem_sh - {1'b0, dv} : rem_sh;
      dq  <= {dq[DIV_W-2:0], q_bit};
    end
  end

  // integer square root, two radicand bits per cycle
  logic [ROOT_W-1:0] rx, rres, rbit, rtry;
  assign rtry = rres + rbit;

  always_ff @(posedge clk) begin
    if (cmd.sq_ld) begin
      rx   <= (dq > ROOT_CAP) ? ROOT_W'(ROOT_CAP) : ROOT_W'(dq);
      rres <= '0;
      rbit <= ROOT_TOP;
    end else if (cmd.sq_step) begin
      if (rx >= rtry) begin
        rx   <= rx - rtry;
        rres <= (rres >> 1) + rbit;
      end else begin
        rres <= rres >> 1;
      end
      rbit <= rbit >> 2;
    end
  end

  logic signed [MEAN_W-1:0] mean_r;
  logic [STD_W-1:0]         stdev_r;

  always_ff @(posedge clk) begin
    if (cmd.mean_fin) begin
      if (ent.sum[SUM_W-1]) mean_r <= MEAN_W'(-((dq > MEAN_NEG_MAX) ? MEAN_NEG_MAX : dq));
      else mean_r <= MEAN_W'((dq > MEAN_POS_MAX) ? MEAN_POS_MAX : dq);
    end
    if (cmd.std_clr) stdev_r <= '0;
    else if (cmd.std_fin) stdev_r <= (rres > STD_SAT) ? '1 : rres[STD_W-1:0];
  end

  assign status.clr_last = (clr_addr == ADDR_W'(BIN_COUNT - 1));
  assign status.n_ge1    = (ent.valid != '0);
  assign status.n_ge2    = (ent.valid > CNT_W'(1));
  assign status.var_pos  = (a_acc > b_acc);

  assign bin_out     = req_bin;
  assign total_count = ent.total;
  assign nan_count   = ent.total - ent.valid;
  assign has_values  = status.n_ge1;
  assign has_stdev   = status.n_ge2;
  assign overflow    = ent.ovf;
  assign min_value   = has_values ? ent.minv : '0;
  assign max_value   = has_values ? ent.maxv : '0;
  assign sum_value   = has_values ? ent.sum : '0;
  assign mean_value  = has_values ? mean_r : '0;
  assign stdev_value = has_stdev ? stdev_r : '0;

endmodule

// ===== src/binned_summary_statistics_top.sv =====
// accumulate item: table read at accept, read-modify-write in the next cycle
// report item: an empty bin skips the arithmetic; one valid sample runs only the mean divide
//   (128-step serial divider); two or more with positive variance also divide for deviation
//   and run the 25-step square root; result_valid pulses one cycle, receiver cannot stall
// reset (synchronous) runs a clearing pass over every bin of the table, busy held high
module binned_summary_statistics_top (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   operation,
  input  logic [bss_pkg::BIN_W-1:0]              bin,
  input  logic signed [bss_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   sample_is_nan,
  output logic                                   result_valid,
  output logic [bss_pkg::BIN_W-1:0]              bin_out,
  output logic [bss_pkg::CNT_W-1:0]              total_count,
  output logic [bss_pkg::CNT_W-1:0]              nan_count,
  output logic signed [bss_pkg::SAMPLE_BITS-1:0] min_value,
  output logic signed [bss_pkg::SAMPLE_BITS-1:0] max_value,
  output logic signed [bss_pkg::SUM_W-1:0]       sum_value,
  output logic signed [bss_pkg::MEAN_W-1:0]      mean_value,
  output logic [bss_pkg::STD_W-1:0]              stdev_value,
  output logic                                   has_values,
  output logic                                   has_stdev,
  output logic                                   overflow
);
  import bss_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    accept;

  assign accept = start && !busy;

  bss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .operation    (operation),
    .status       (status),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  bss_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .accept        (accept),
    .bin           (bin),
    .sample        (sample),
    .sample_is_nan (sample_is_nan),
    .bin_out       (bin_out),
    .total_count   (total_count),
    .nan_count     (nan_count),
    .min_value     (min_value),
    .max_value     (max_value),
    .sum_value     (sum_value),
    .mean_value    (mean_value),
    .stdev_value   (stdev_value),
    .has_values    (has_values),
    .has_stdev     (has_stdev),
    .overflow      (overflow)
  );

endmodule
